@@ hw/rtl/pbpc_pkg.sv @@
`default_nettype none

package pbpc_pkg;

    localparam int LEVEL_BITS = 5;
    localparam int NUM_SLOTS  = 4;
    localparam int THR_BITS   = 8;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_OFF   = 2'd1,
        REQ_ON    = 2'd2,
        REQ_CYCLE = 2'd3
    } pbpc_req_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SLED_CYCLE_MIN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CYCLE_MIN      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFF_MIN        = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ON_MIN         = 2'd3;

    localparam logic [THR_BITS-1:0] SLED_CYCLE_MIN_RST = 8'd4;
    localparam logic [THR_BITS-1:0] CYCLE_MIN_RST      = 8'd4;
    localparam logic [THR_BITS-1:0] OFF_MIN_RST        = 8'd8;
    localparam logic [THR_BITS-1:0] ON_MIN_RST         = 8'd1;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] button_levels;
        logic [NUM_SLOTS-1:0]  slot_power_off;
    } pbpc_in_t;

    typedef struct packed {
        logic       sled_request;
        logic [1:0] slot1_request;
        logic [1:0] slot2_request;
        logic [1:0] slot3_request;
        logic [1:0] slot4_request;
    } pbpc_out_t;

    typedef struct packed {
        logic [THR_BITS-1:0] sled_cycle_min_ticks;
        logic [THR_BITS-1:0] cycle_min_ticks;
        logic [THR_BITS-1:0] off_min_ticks;
        logic [THR_BITS-1:0] on_min_ticks;
    } pbpc_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/pbpc_cfg.sv @@
`default_nettype none

module pbpc_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pbpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [pbpc_pkg::THR_BITS-1:0]      cfg_data,
    output pbpc_pkg::pbpc_cfg_t                     cfg
);
    import pbpc_pkg::*;

    pbpc_cfg_t cfg_reg;
    pbpc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLED_CYCLE_MIN: cfg_next.sled_cycle_min_ticks = cfg_data;
                CFG_CYCLE_MIN:      cfg_next.cycle_min_ticks      = cfg_data;
                CFG_OFF_MIN:        cfg_next.off_min_ticks        = cfg_data;
                CFG_ON_MIN:         cfg_next.on_min_ticks         = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sled_cycle_min_ticks <= SLED_CYCLE_MIN_RST;
            cfg_reg.cycle_min_ticks      <= CYCLE_MIN_RST;
            cfg_reg.off_min_ticks        <= OFF_MIN_RST;
            cfg_reg.on_min_ticks         <= ON_MIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pbpc_counter.sv @@
`default_nettype none

module pbpc_counter #(
    parameter int COUNT_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  pressed,
    output logic [COUNT_BITS-1:0]      count,
    output logic                       released
);
    import pbpc_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (advance)
        begin
            if (pressed)
            begin
                if (count_reg != {COUNT_BITS{1'b1}})
                begin
                    count_next = count_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
                end
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count    = count_reg;
    assign released = !pressed && (count_reg != '0);

endmodule

`default_nettype wire

@@ hw/rtl/power_button_press_classifier.sv @@
// Power button press classifier. Each accepted request is one sampling tick
// carrying five active-low button levels (baseboard, then slots 1-4) and the
// 12V-off status of each slot; every request yields exactly one result in
// the next cycle, and a new request is taken every cycle while the result
// register is empty or being drained (one tick per cycle, set by the single
// result register). Per-button held-tick counters saturate and are
// classified on release against the four threshold registers written
// through the cfg port: baseboard press above sled_cycle_min_ticks requests
// a sled cycle; a slot press on an unpowered slot of at least on_min_ticks
// requests 12V on, otherwise above cycle_min_ticks requests 12V cycle, or
// 12V off when also above off_min_ticks.
`default_nettype none

module power_button_press_classifier #(
    parameter int NUM_BUTTONS = 5,
    parameter int COUNT_BITS  = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire pbpc_pkg::pbpc_in_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output pbpc_pkg::pbpc_out_t                     out_data,
    input  wire logic                               cfg_we,
    input  wire logic [pbpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [pbpc_pkg::THR_BITS-1:0]      cfg_data
);
    import pbpc_pkg::*;

    localparam int NUM_LIVE = (NUM_BUTTONS < LEVEL_BITS) ? NUM_BUTTONS : LEVEL_BITS;
    localparam int CMP_W    = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

    pbpc_cfg_t cfg;
    logic      accept;

    logic [COUNT_BITS-1:0] count_w [NUM_LIVE];
    logic [NUM_LIVE-1:0]   rel_w;
    pbpc_req_t             slot_req [NUM_SLOTS];
    logic                  sled_w;

    pbpc_out_t out_data_reg;
    pbpc_out_t out_data_next;
    logic      out_valid_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    pbpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    for (genvar b = 0; b < NUM_LIVE; b++)
    begin : g_btn
        pbpc_counter #(
            .COUNT_BITS (COUNT_BITS)
        ) u_counter (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (accept),
            .pressed  (!in_data.button_levels[b]),
            .count    (count_w[b]),
            .released (rel_w[b])
        );
    end

    logic [CMP_W-1:0] cnt0_x;
    assign cnt0_x = CMP_W'(count_w[0]);
    assign sled_w = rel_w[0] && (cnt0_x > CMP_W'(cfg.sled_cycle_min_ticks));

    for (genvar s = 0; s < NUM_SLOTS; s++)
    begin : g_slot
        if (s + 1 < NUM_LIVE)
        begin : g_live
            logic [CMP_W-1:0] cnt_x;
            assign cnt_x = CMP_W'(count_w[s+1]);
            always_comb
            begin
                slot_req[s] = REQ_NONE;
                if (rel_w[s+1])
                begin
                    if (in_data.slot_power_off[s]
                        && (cnt_x >= CMP_W'(cfg.on_min_ticks)))
                    begin
                        slot_req[s] = REQ_ON;
                    end
                    else if (cnt_x > CMP_W'(cfg.cycle_min_ticks))
                    begin
                        slot_req[s] = (cnt_x <= CMP_W'(cfg.off_min_ticks))
                                      ? REQ_CYCLE : REQ_OFF;
                    end
                end
            end
        end
        else
        begin : g_absent
            assign slot_req[s] = REQ_NONE;
        end
    end

    always_comb
    begin
        out_data_next.sled_request  = sled_w;
        out_data_next.slot1_request = slot_req[0];
        out_data_next.slot2_request = slot_req[1];
        out_data_next.slot3_request = slot_req[2];
        out_data_next.slot4_request = slot_req[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request did not produce a result");

    a_held_base_no_sled: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_data.button_levels[0]) |=> !out_data.sled_request)
        else $error("sled request while baseboard button held");

    a_held_slot1_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_data.button_levels[1]) |=> (out_data.slot1_request == REQ_NONE))
        else $error("slot 1 request while its button held");

    a_idle_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!accept && out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("pending result changed without a new request");

endmodule

`default_nettype wire
